>>> sv/bdlp_pkg.sv
// Shared types, constants and helpers for the button debounce block.
package bdlp_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int COUNT_WIDTH = 16;
	localparam int FIELD_BITS  = 4;
	localparam int REG_WIDTH   = 16;
	localparam int DUR_WIDTH   = 16;
	localparam int CMP_WIDTH   = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;
	localparam int IDX_WIDTH   = 3;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [REG_WIDTH-1:0]   reg_t;

	typedef enum logic [IDX_WIDTH-1:0] {
		REG_DEBOUNCE     = 3'd0,
		REG_LONG_PRESS   = 3'd1,
		REG_REPEAT_DELAY = 3'd2,
		REG_REPEAT_PER   = 3'd3
	} reg_index_t;

	localparam reg_t DEBOUNCE_RST     = 16'd50;
	localparam reg_t LONG_PRESS_RST   = 16'd1000;
	localparam reg_t REPEAT_DELAY_RST = 16'd500;
	localparam reg_t REPEAT_PER_RST   = 16'd100;

	typedef struct packed {
		reg_t debounce_ms;
		reg_t long_press_ms;
		reg_t repeat_delay_ms;
		reg_t repeat_period_ms;
	} cfg_regs_t;

	typedef struct packed {
		logic held;
		logic repeating;
		logic click_flag;
		logic long_flag;
		cnt_t hold_count;
	} lane_status_t;

	function automatic cnt_t sat_inc(cnt_t v);
		return (v == {COUNT_WIDTH{1'b1}}) ? v : cnt_t'(v + 1'b1);
	endfunction

	function automatic logic cnt_ge(cnt_t c, reg_t t);
		return CMP_WIDTH'(c) >= CMP_WIDTH'(t);
	endfunction

	function automatic logic cnt_gt(cnt_t c, reg_t t);
		return CMP_WIDTH'(c) > CMP_WIDTH'(t);
	endfunction

	function automatic logic [DUR_WIDTH-1:0] dur_clip(cnt_t c);
		logic [CMP_WIDTH:0] w;
		w = (CMP_WIDTH + 1)'(c);
		if (w > (CMP_WIDTH + 1)'({DUR_WIDTH{1'b1}}))
			return {DUR_WIDTH{1'b1}};
		return w[DUR_WIDTH-1:0];
	endfunction

endpackage

>>> sv/button_debounce_long_press_repeat.sv
// Top level of the four-button debounce, long-press and autorepeat front end.
//
// Each input beat is one millisecond tick: raw active-low pin levels plus
// read-and-clear masks for the click and long-press flags; the clears apply
// before the tick's update. Every button has its own lane that debounces the
// pin (a level is taken once it has been quiet for more than debounce_ms
// ticks), times the press, and latches click, long-press and autorepeat
// events. All lanes update side by side in the cycle a beat is accepted; a
// merge stage then collects their flags into four-bit masks, picks the hold
// time of the button named by query_index (0 when it is not pressed) and
// registers one result beat. Throughput is one tick per clock while in_stall
// is low, and each result appears in the cycle after its tick is accepted.
// The single output register sets the rate: a new tick is taken whenever the
// output is empty or is being taken in the same cycle, so in_stall only rises
// while a result waits under out_stall. Counters saturate at their maximum.
// Configuration (cfg_we, cfg_index, cfg_data) writes registers 0..3 at any
// clock edge with cfg_we high; indexes above 3 are ignored. Write only while
// no tick is in flight.
module button_debounce_long_press_repeat import bdlp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration port
	input  logic                  cfg_we,
	input  logic [IDX_WIDTH-1:0]  cfg_index,
	input  logic [REG_WIDTH-1:0]  cfg_data,
	// tick channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [FIELD_BITS-1:0] raw_levels,
	input  logic [FIELD_BITS-1:0] clear_click,
	input  logic [FIELD_BITS-1:0] clear_long,
	input  logic [1:0]            query_index,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [FIELD_BITS-1:0] pressed_mask,
	output logic [FIELD_BITS-1:0] repeating_mask,
	output logic [FIELD_BITS-1:0] click_flags,
	output logic [FIELD_BITS-1:0] long_flags,
	output logic [DUR_WIDTH-1:0]  press_duration
);

	cfg_regs_t    cfg_q;
	lane_status_t lane_next [NUM_BUTTONS];
	logic         accept;

	// Hold the tick only while a finished beat is still blocked downstream.
	assign in_stall = out_valid & out_stall;
	assign accept   = in_valid & ~in_stall;

	// Register file; writes to unknown indexes drop silently.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms      <= DEBOUNCE_RST;
			cfg_q.long_press_ms    <= LONG_PRESS_RST;
			cfg_q.repeat_delay_ms  <= REPEAT_DELAY_RST;
			cfg_q.repeat_period_ms <= REPEAT_PER_RST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_DEBOUNCE:     cfg_q.debounce_ms      <= cfg_data;
				REG_LONG_PRESS:   cfg_q.long_press_ms    <= cfg_data;
				REG_REPEAT_DELAY: cfg_q.repeat_delay_ms  <= cfg_data;
				REG_REPEAT_PER:   cfg_q.repeat_period_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// One lane per button; buttons past the pin fields read as released.
	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		logic lvl, clr_c, clr_l;
		if (i < FIELD_BITS) begin : g_pin
			assign lvl   = raw_levels[i];
			assign clr_c = clear_click[i];
			assign clr_l = clear_long[i];
		end else begin : g_nopin
			assign lvl   = 1'b1;
			assign clr_c = 1'b0;
			assign clr_l = 1'b0;
		end
		bdlp_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.accept      (accept),
			.level       (lvl),
			.clr_click   (clr_c),
			.clr_long    (clr_l),
			.cfg         (cfg_q),
			.status_next (lane_next[i])
		);
	end

	// Combine lane results and register the result beat.
	bdlp_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.query_index    (query_index),
		.lanes          (lane_next),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.pressed_mask   (pressed_mask),
		.repeating_mask (repeating_mask),
		.click_flags    (click_flags),
		.long_flags     (long_flags),
		.press_duration (press_duration)
	);

endmodule

>>> sv/bdlp_lane.sv
// One button lane: debounce, hold timing, long-press and autorepeat flags.
module bdlp_lane import bdlp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  logic         level,
	input  logic         clr_click,
	input  logic         clr_long,
	input  cfg_regs_t    cfg,
	output lane_status_t status_next
);

	logic prev_q, stable_q, held_q, arep_q, click_q, long_q;
	cnt_t quiet_q, hold_q, rep_q;

	logic prev_d, stable_d, held_d, arep_d, click_d, long_d;
	cnt_t quiet_d, hold_d, rep_d;

	always_comb begin
		click_d  = click_q & ~clr_click;
		long_d   = long_q & ~clr_long;
		quiet_d  = (level != prev_q) ? '0 : sat_inc(quiet_q);
		hold_d   = held_q ? sat_inc(hold_q) : hold_q;
		rep_d    = sat_inc(rep_q);
		held_d   = held_q;
		arep_d   = arep_q;
		stable_d = stable_q;
		prev_d   = level;

		if (cnt_gt(quiet_d, cfg.debounce_ms) && (level != stable_q)) begin
			stable_d = level;
			if (!level) begin
				held_d  = 1'b1;
				hold_d  = '0;
				rep_d   = '0;
				arep_d  = 1'b0;
				click_d = 1'b0;
				long_d  = 1'b0;
			end else begin
				if (cnt_ge(hold_d, cfg.long_press_ms))
					long_d = 1'b1;
				else
					click_d = 1'b1;
				held_d = 1'b0;
				arep_d = 1'b0;
			end
		end

		if (held_d && !long_d) begin
			if (cnt_ge(hold_d, cfg.long_press_ms))
				long_d = 1'b1;
			if (!arep_d) begin
				if (cnt_ge(hold_d, cfg.repeat_delay_ms)) begin
					arep_d = 1'b1;
					rep_d  = '0;
				end
			end else if (cnt_ge(rep_d, cfg.repeat_period_ms)) begin
				click_d = 1'b1;
				rep_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b1;
			stable_q <= 1'b1;
			held_q   <= 1'b0;
			arep_q   <= 1'b0;
			click_q  <= 1'b0;
			long_q   <= 1'b0;
			quiet_q  <= '0;
			hold_q   <= '0;
			rep_q    <= '0;
		end else if (accept) begin
			prev_q   <= prev_d;
			stable_q <= stable_d;
			held_q   <= held_d;
			arep_q   <= arep_d;
			click_q  <= click_d;
			long_q   <= long_d;
			quiet_q  <= quiet_d;
			hold_q   <= hold_d;
			rep_q    <= rep_d;
		end
	end

	assign status_next = '{held: held_d, repeating: arep_d, click_flag: click_d,
		long_flag: long_d, hold_count: hold_d};

	a_arep_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		arep_q |-> held_q) else $error("autorepeat active on a released button");
	a_held_tracks_stable: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == !stable_q) else $error("held disagrees with stable level");
	a_hold_frozen_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(hold_q) && $stable(held_q))
		else $error("lane state moved without a tick");

endmodule

>>> sv/bdlp_merge.sv
// Merge stage: gather lane results into masks and the queried duration, register the beat.
module bdlp_merge import bdlp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [1:0]            query_index,
	input  lane_status_t          lanes [NUM_BUTTONS],
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [FIELD_BITS-1:0] pressed_mask,
	output logic [FIELD_BITS-1:0] repeating_mask,
	output logic [FIELD_BITS-1:0] click_flags,
	output logic [FIELD_BITS-1:0] long_flags,
	output logic [DUR_WIDTH-1:0]  press_duration
);

	logic [FIELD_BITS-1:0] pm, rm, cm, lm;
	logic [DUR_WIDTH-1:0]  dur;
	logic                  valid_q;

	always_comb begin
		pm  = '0;
		rm  = '0;
		cm  = '0;
		lm  = '0;
		dur = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (i < FIELD_BITS) begin
				pm[i] = lanes[i].held;
				rm[i] = lanes[i].repeating;
				cm[i] = lanes[i].click_flag;
				lm[i] = lanes[i].long_flag;
				if ((int'(query_index) == i) && lanes[i].held)
					dur = dur_clip(lanes[i].hold_count);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (accept)
			valid_q <= 1'b1;
		else if (!out_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pressed_mask   <= pm;
			repeating_mask <= rm;
			click_flags    <= cm;
			long_flags     <= lm;
			press_duration <= dur;
		end
	end

	assign out_valid = valid_q;

endmodule
